// ===== src/plane_slot_reservation_table_assert.svh =====
// ----------------------------------------------------------------------------
// Plane slot reservation table: assertion macros
// Concurrent assertion forms used by the block's datapath module.
// ----------------------------------------------------------------------------
`ifndef PLANE_SLOT_RESERVATION_TABLE_ASSERT_SVH
`define PLANE_SLOT_RESERVATION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pstr_pkg.sv =====
// ----------------------------------------------------------------------------
// Plane slot reservation table package
// Field widths, operation and status codes, and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pstr_pkg;

  localparam int FUNC_W    = 2;
  localparam int OUTPUT_W  = 4;
  localparam int SLOT_W    = 8;
  localparam int SURFACE_W = 12;
  localparam int STATUS_W  = 3;
  localparam int KEY_W     = OUTPUT_W + SLOT_W;
  localparam int ENTRY_W   = KEY_W + SURFACE_W;

  localparam logic [FUNC_W-1:0] FN_ASSIGN  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVAL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNAVAIL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic capture;
    logic append;
    logic move_rd;
    logic move_wr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic hit;
    logic miss;
    logic do_append;
    logic do_remove;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/pstr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Plane slot reservation table controller
// Sequences one operation: argument check, table scan, update and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pstr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire pstr_pkg::stat_t stat,
  output pstr_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                done
);

  import pstr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_APPEND  = 7'b0001000,
    S_MOVE_RD = 7'b0010000,
    S_MOVE_WR = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.need_scan) begin
          state_next = S_SCAN;
        end else begin
          cmd.capture = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.miss) begin
          cmd.capture = 1'b1;
          if (stat.do_append) begin
            state_next = S_APPEND;
          end else if (stat.do_remove) begin
            state_next = S_MOVE_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_DONE;
      end
      S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_next  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

`default_nettype wire

// ===== src/pstr_dp.sv =====
// ----------------------------------------------------------------------------
// Plane slot reservation table datapath
// Holds the packed entry memory, the entry count, the scan pointer and the
// result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "plane_slot_reservation_table_assert.svh"

module pstr_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pstr_pkg::cmd_t                    cmd,
  output pstr_pkg::stat_t                        stat,
  input  wire logic [pstr_pkg::FUNC_W-1:0]       func,
  input  wire logic [pstr_pkg::OUTPUT_W-1:0]     output_id,
  input  wire logic [pstr_pkg::SLOT_W-1:0]       slot_id,
  input  wire logic [pstr_pkg::SURFACE_W-1:0]    surface_id,
  input  wire logic                              slot_chosen,
  input  wire logic                              slot_exists,
  input  wire logic                              slot_compatible,
  output logic [pstr_pkg::STATUS_W-1:0]          status,
  output logic [pstr_pkg::SLOT_W-1:0]            granted_slot,
  output logic                                   held
);

  import pstr_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  // Latched operation.
  logic [FUNC_W-1:0]    func_q;
  logic [OUTPUT_W-1:0]  output_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [SURFACE_W-1:0] surface_q;
  logic                 chosen_q;
  logic                 exists_q;
  logic                 compat_q;

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic [IW-1:0]      rd_idx;
  logic               rd_en;
  logic [IW-1:0]      wr_idx;
  logic [ENTRY_W-1:0] wr_data;
  logic               wr_en;

  logic [CW-1:0] count;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] rd_addr;
  logic [IW-1:0] cmp_idx;
  logic          cmp_vld;
  logic          cmp_end;
  logic [IW-1:0] hit_idx;

  logic key_match;
  logic holder_ok;
  logic full;
  logic args_ok;

  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   granted_next;
  logic                held_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q    <= func;
      output_q  <= output_id;
      slot_q    <= slot_id;
      surface_q <= surface_id;
      chosen_q  <= slot_chosen;
      exists_q  <= slot_exists;
      compat_q  <= slot_compatible;
    end
  end

  assign count_dec = count - CW'(1);
  assign full      = (count == FULL_COUNT);
  assign args_ok   = (output_q != '0) && (surface_q != '0);

  // Entry memory: one write port, one registered read port.
  assign rd_en   = cmd.scan || cmd.move_rd;
  assign rd_idx  = cmd.move_rd ? count_dec[IW-1:0] : rd_addr[IW-1:0];
  assign wr_en   = cmd.append || (cmd.move_wr && (CW'(hit_idx) != count));
  assign wr_idx  = cmd.append ? count[IW-1:0] : hit_idx;
  assign wr_data = cmd.append ? {output_q, slot_q, surface_q} : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Scan pointer. The compare stage (cmp_idx, cmp_vld) is registered from the read address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      cmp_vld <= 1'b0;
      cmp_end <= 1'b0;
    end else if (cmd.check) begin
      rd_addr <= '0;
      cmp_vld <= 1'b0;
      cmp_end <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld <= (rd_addr < count);
      cmp_end <= (rd_addr >= count);
      if (rd_addr < count) begin
        rd_addr <= rd_addr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= rd_addr[IW-1:0];
    end
    if (cmd.capture) begin
      hit_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CW'(1);
    end else if (cmd.move_rd) begin
      count <= count_dec;
    end
  end

  assign key_match = (rd_data[ENTRY_W-1:SURFACE_W] == {output_q, slot_q});
  assign holder_ok = (rd_data[SURFACE_W-1:0] == surface_q);

  always_comb begin
    stat.need_scan = ((func_q == FN_ASSIGN) && args_ok && chosen_q && exists_q) ||
                     ((func_q == FN_RELEASE) && (output_q != '0)) ||
                     (func_q == FN_QUERY);
    stat.hit       = cmp_vld && key_match;
    stat.miss      = cmp_end;
    stat.do_append = stat.miss && (func_q == FN_ASSIGN) && compat_q && !full;
    stat.do_remove = stat.hit && (func_q == FN_RELEASE) && holder_ok;
  end

  always_comb begin
    status_next  = ST_OK;
    granted_next = '0;
    held_next    = 1'b0;
    unique case (func_q)
      FN_ASSIGN: begin
        if (!args_ok) begin
          status_next = ST_INVAL;
        end else if (!chosen_q) begin
          status_next = ST_NOSLOT;
        end else if (!exists_q) begin
          status_next = ST_UNAVAIL;
        end else if (stat.hit) begin
          // The present holder gets its own slot back regardless of format.
          if (holder_ok) begin
            granted_next = slot_q;
          end else begin
            status_next = ST_UNAVAIL;
          end
        end else if (!compat_q) begin
          status_next = ST_UNAVAIL;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          granted_next = slot_q;
        end
      end
      FN_RELEASE: begin
        status_next = ST_OK;
      end
      FN_QUERY: begin
        held_next = stat.hit && holder_ok;
      end
      default: begin
        status_next = ST_INVAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status       <= status_next;
      granted_slot <= granted_next;
      held         <= held_next;
    end
  end

  `PSRT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FULL_COUNT, "entry count overflow")
  `PSRT_ASSERT_NOW(a_append_room, clk, rst, cmd.append, !full, "append into a full table")
  `PSRT_ASSERT_NEXT(a_remove_dec, clk, rst, cmd.move_rd && !rst, count == $past(count_dec), "remove did not shrink table")

endmodule

`default_nettype wire

// ===== src/plane_slot_reservation_table.sv =====
// ----------------------------------------------------------------------------
// Plane slot reservation table
// Packed table of (output, slot) reservations naming the holding surface,
// with assign, release and held-by query operations.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// request   start, busy          func, output_id, slot_id, surface_id,
//                                slot_chosen, slot_exists, slot_compatible
// result    done (one cycle)     status, granted_slot, held
//
// For operations that scan, the time to the done beat depends on N, the
// number of stored entries: the linear scan of the entry memory reads one
// entry per cycle through its single read port until a hit or the end.
// busy stays high up to and including the done cycle, so the next request is
// taken the cycle after. Reset clears the entry count; no clearing pass.
// The receiver cannot stall: done is high for a single cycle, and status,
// granted_slot and held stay until the next operation captures new ones.
`timescale 1ns / 1ps
`default_nettype none

module plane_slot_reservation_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [pstr_pkg::FUNC_W-1:0]    func,
  input  wire logic [pstr_pkg::OUTPUT_W-1:0]  output_id,
  input  wire logic [pstr_pkg::SLOT_W-1:0]    slot_id,
  input  wire logic [pstr_pkg::SURFACE_W-1:0] surface_id,
  input  wire logic                           slot_chosen,
  input  wire logic                           slot_exists,
  input  wire logic                           slot_compatible,
  output logic                                done,
  output logic [pstr_pkg::STATUS_W-1:0]       status,
  output logic [pstr_pkg::SLOT_W-1:0]         granted_slot,
  output logic                                held
);

  import pstr_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_busy;

  pstr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (ctrl_busy),
    .done  (done)
  );

  pstr_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .func            (func),
    .output_id       (output_id),
    .slot_id         (slot_id),
    .surface_id      (surface_id),
    .slot_chosen     (slot_chosen),
    .slot_exists     (slot_exists),
    .slot_compatible (slot_compatible),
    .status          (status),
    .granted_slot    (granted_slot),
    .held            (held)
  );

  assign busy = ctrl_busy;

endmodule

`default_nettype wire
